// ----- hdl/ffbpa_pkg.sv -----
// Shared types, codes and defaults for the first-fit block pool allocator.
package ffbpa_pkg;

  localparam int POOL_BYTES_DEF  = 4096;
  localparam int MAX_ENTRIES_DEF = 16;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;

  localparam logic [2:0] ST_NEW        = 3'd0;
  localparam logic [2:0] ST_REUSED     = 3'd1;
  localparam logic [2:0] ST_FREED      = 3'd2;
  localparam logic [2:0] ST_BAD_SIZE   = 3'd3;
  localparam logic [2:0] ST_NO_MEM     = 3'd4;
  localparam logic [2:0] ST_FULL       = 3'd5;
  localparam logic [2:0] ST_BAD_FREE   = 3'd6;
  localparam logic [2:0] ST_NULL_CLEAR = 3'd7;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] request_size;
    logic [11:0] block_offset;
    logic        offset_is_null;
  } cmd_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] result_offset;
    logic [12:0] used_bytes;
    logic [4:0]  block_count;
  } result_word_t;

  typedef enum logic [1:0] {
    K_ALLOC  = 2'd0,
    K_FREE   = 2'd1,
    K_CLEAR  = 2'd2,
    K_REPORT = 2'd3
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [15:0] size;
    logic [11:0] offset;
    logic [2:0]  status;
  } op_word_t;

  typedef struct packed {
    logic [11:0] offset;
    logic [12:0] size;
    logic        is_free;
  } entry_t;

endpackage

// ----- hdl/first_fit_block_pool_allocator_unit.sv -----
// Top level of the first-fit block pool allocator.
//
// A command word is taken on request at a rising edge where start is high and busy
// is low. The command allocates a size, frees a block by its offset, or clears the
// whole pool. Every command gives exactly one result word on result, marked by done
// for a single cycle; the receiver cannot hold results off.
// A front end classifies commands and keeps up to two of them queued, so busy rises
// only when both queue slots hold words the back end has not yet taken.
// Clears, rejected sizes, null frees, allocations refused on the used-byte or table-full
// check and commands that find the table empty finish in the back end straight from idle;
// done is registered after the command has passed through its queue slot. Allocations
// and frees that search the block table read one table entry per cycle through the read
// port of the table memory, and the back end pops no new command until a search ends.
// Reset empties the queue and zeroes the used-byte count, bump offset and block count;
// table entries are not cleared, since only entries below the block count are read.
module first_fit_block_pool_allocator_unit #(
  parameter int POOL_BYTES  = ffbpa_pkg::POOL_BYTES_DEF,
  parameter int MAX_ENTRIES = ffbpa_pkg::MAX_ENTRIES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  ffbpa_pkg::cmd_word_t    request,
  output logic                    busy,
  output logic                    done,
  output ffbpa_pkg::result_word_t result
);

  logic                q_valid;
  logic                q_pop;
  ffbpa_pkg::op_word_t q_word;

  ffbpa_front #(
    .POOL_BYTES(POOL_BYTES)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .request(request),
    .busy   (busy),
    .q_valid(q_valid),
    .q_word (q_word),
    .q_pop  (q_pop)
  );

  ffbpa_back #(
    .POOL_BYTES (POOL_BYTES),
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .q_word (q_word),
    .q_pop  (q_pop),
    .done   (done),
    .result (result)
  );

endmodule

// ----- hdl/ffbpa_front.sv -----
// Command front end: classifies each command word and queues it for the back end.
module ffbpa_front #(
  parameter int POOL_BYTES = ffbpa_pkg::POOL_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  ffbpa_pkg::cmd_word_t request,
  output logic                 busy,
  output logic                 q_valid,
  output ffbpa_pkg::op_word_t  q_word,
  input  logic                 q_pop
);

  localparam logic [16:0] POOL_LIM = 17'(POOL_BYTES);

  ffbpa_pkg::op_word_t classified;
  ffbpa_pkg::op_word_t slot [2];
  logic [1:0] fill;
  logic [1:0] fill_next;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push;

  always_comb begin
    classified.size   = request.request_size;
    classified.offset = request.block_offset;
    classified.status = ffbpa_pkg::ST_NULL_CLEAR;
    classified.kind   = ffbpa_pkg::K_CLEAR;
    if (request.command == ffbpa_pkg::CMD_ALLOC) begin
      if (request.request_size == 16'd0 || {1'b0, request.request_size} > POOL_LIM) begin
        classified.kind   = ffbpa_pkg::K_REPORT;
        classified.status = ffbpa_pkg::ST_BAD_SIZE;
      end else begin
        classified.kind = ffbpa_pkg::K_ALLOC;
      end
    end else if (request.command == ffbpa_pkg::CMD_FREE) begin
      if (request.offset_is_null) begin
        classified.kind   = ffbpa_pkg::K_REPORT;
        classified.status = ffbpa_pkg::ST_NULL_CLEAR;
      end else begin
        classified.kind = ffbpa_pkg::K_FREE;
      end
    end
  end

  assign busy    = (fill == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (fill != 2'd0);
  assign q_word  = slot[rd_ptr];

  always_comb begin
    fill_next = fill;
    if (push && !q_pop) begin
      fill_next = fill + 2'd1;
    end else if (!push && q_pop) begin
      fill_next = fill - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      fill <= fill_next;
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= classified;
    end
  end

endmodule

// ----- hdl/ffbpa_back.sv -----
// Command back end: block table, pool counters and the first-fit search sequencer.
module ffbpa_back #(
  parameter int POOL_BYTES  = ffbpa_pkg::POOL_BYTES_DEF,
  parameter int MAX_ENTRIES = ffbpa_pkg::MAX_ENTRIES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  ffbpa_pkg::op_word_t     q_word,
  output logic                    q_pop,
  output logic                    done,
  output ffbpa_pkg::result_word_t result
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [16:0] POOL_LIM = 17'(POOL_BYTES);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  ffbpa_pkg::op_word_t op;
  logic [IW-1:0] idx;
  logic [IW-1:0] idx_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [12:0]   used;
  logic [12:0]   used_next;
  logic [12:0]   bump;
  logic [12:0]   bump_next;
  logic          done_next;
  ffbpa_pkg::result_word_t result_next;

  ffbpa_pkg::entry_t mem [MAX_ENTRIES];
  ffbpa_pkg::entry_t rd_data;
  ffbpa_pkg::entry_t wr_data;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;
  logic          wr_en;

  logic [15:0] act_size;
  logic [CW:0] idx_inc;
  logic        last;
  logic        reuse_hit;
  logic        free_hit;
  logic        report;
  logic [2:0]  status_next;
  logic [11:0] offset_next;

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign act_size = (state == S_IDLE) ? q_word.size : op.size;
  assign idx_inc  = (CW + 1)'(idx) + 1'b1;
  assign last     = (idx_inc == {1'b0, count});
  assign reuse_hit = rd_data.is_free && ({3'b000, rd_data.size} >= op.size);
  assign free_hit  = !rd_data.is_free && (rd_data.offset == op.offset);

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    count_next  = count;
    used_next   = used;
    bump_next   = bump;
    wr_en       = 1'b0;
    wr_addr     = idx;
    wr_data     = rd_data;
    rd_addr     = idx_inc[IW-1:0];
    report      = 1'b0;
    status_next = ffbpa_pkg::ST_NULL_CLEAR;
    offset_next = 12'd0;

    case (state)
      S_IDLE: begin
        rd_addr = '0;
        idx_next = '0;
        if (q_valid) begin
          case (q_word.kind)
            ffbpa_pkg::K_CLEAR: begin
              count_next  = '0;
              used_next   = 13'd0;
              bump_next   = 13'd0;
              report      = 1'b1;
            end
            ffbpa_pkg::K_REPORT: begin
              report      = 1'b1;
              status_next = q_word.status;
            end
            ffbpa_pkg::K_ALLOC: begin
              if ({4'b0000, used} + {1'b0, q_word.size} > POOL_LIM) begin
                report      = 1'b1;
                status_next = ffbpa_pkg::ST_NO_MEM;
              end else if (count >= MAX_CNT) begin
                report      = 1'b1;
                status_next = ffbpa_pkg::ST_FULL;
              end else if (count != '0) begin
                state_next = S_SCAN;
              end else begin
                report = 1'b1;
                if ({4'b0000, bump} + {1'b0, act_size} > POOL_LIM) begin
                  status_next = ffbpa_pkg::ST_NO_MEM;
                end else begin
                  wr_en          = 1'b1;
                  wr_addr        = count[IW-1:0];
                  wr_data.offset = bump[11:0];
                  wr_data.size   = act_size[12:0];
                  wr_data.is_free = 1'b0;
                  count_next     = count + 1'b1;
                  bump_next      = bump + act_size[12:0];
                  used_next      = used + act_size[12:0];
                  status_next    = ffbpa_pkg::ST_NEW;
                  offset_next    = bump[11:0];
                end
              end
            end
            ffbpa_pkg::K_FREE: begin
              if (count == '0) begin
                report      = 1'b1;
                status_next = ffbpa_pkg::ST_BAD_FREE;
              end else begin
                state_next = S_SCAN;
              end
            end
            default: begin
              report = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        idx_next = idx_inc[IW-1:0];
        if (op.kind == ffbpa_pkg::K_ALLOC) begin
          if (reuse_hit) begin
            wr_en           = 1'b1;
            wr_data.is_free = 1'b0;
            used_next       = used + rd_data.size;
            report          = 1'b1;
            status_next     = ffbpa_pkg::ST_REUSED;
            offset_next     = rd_data.offset;
            state_next      = S_IDLE;
          end else if (last) begin
            report     = 1'b1;
            state_next = S_IDLE;
            if ({4'b0000, bump} + {1'b0, act_size} > POOL_LIM) begin
              status_next = ffbpa_pkg::ST_NO_MEM;
            end else begin
              wr_en           = 1'b1;
              wr_addr         = count[IW-1:0];
              wr_data.offset  = bump[11:0];
              wr_data.size    = act_size[12:0];
              wr_data.is_free = 1'b0;
              count_next      = count + 1'b1;
              bump_next       = bump + act_size[12:0];
              used_next       = used + act_size[12:0];
              status_next     = ffbpa_pkg::ST_NEW;
              offset_next     = bump[11:0];
            end
          end
        end else begin
          if (free_hit) begin
            wr_en           = 1'b1;
            wr_data.is_free = 1'b1;
            used_next       = (used >= rd_data.size) ? used - rd_data.size : 13'd0;
            report          = 1'b1;
            status_next     = ffbpa_pkg::ST_FREED;
            state_next      = S_IDLE;
          end else if (last) begin
            report      = 1'b1;
            status_next = ffbpa_pkg::ST_BAD_FREE;
            state_next  = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    done_next                 = report;
    result_next.status        = status_next;
    result_next.result_offset = offset_next;
    result_next.used_bytes    = used_next;
    result_next.block_count   = 5'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      used  <= 13'd0;
      bump  <= 13'd0;
      done  <= 1'b0;
      idx   <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      used  <= used_next;
      bump  <= bump_next;
      done  <= done_next;
      idx   <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (q_pop) begin
      op <= q_word;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hdl/ffbpa_checker.sv -----
// Port-level checks for the first-fit block pool allocator, bound to the top level.
module ffbpa_port_checks #(
  parameter int POOL_BYTES  = ffbpa_pkg::POOL_BYTES_DEF,
  parameter int MAX_ENTRIES = ffbpa_pkg::MAX_ENTRIES_DEF
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    start,
  input logic                    busy,
  input logic                    done,
  input ffbpa_pkg::result_word_t result
);

  a_no_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_busy_needs_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command word being taken");

  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ffbpa_pkg::ST_NEW && result.status != ffbpa_pkg::ST_REUSED)
      |-> (result.result_offset == 12'd0))
    else $error("nonzero offset on a result that allocated nothing");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> ((MAX_ENTRIES > 31) || (32'(result.block_count) <= MAX_ENTRIES)))
    else $error("block count above table size");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ffbpa_pkg::ST_FULL)
      |-> (result.block_count == 5'(MAX_ENTRIES)))
    else $error("table full reported with free table entries");

endmodule

bind first_fit_block_pool_allocator_unit ffbpa_port_checks #(
  .POOL_BYTES (POOL_BYTES),
  .MAX_ENTRIES(MAX_ENTRIES)
) u_ffbpa_port_checks (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

// ----- tb/sv/ffbpa_checker.sv -----
// Checker that predicts and compares every result word of the pool allocator.
module ffbpa_checker #(
  parameter int POOL_BYTES  = ffbpa_pkg::POOL_BYTES_DEF,
  parameter int MAX_ENTRIES = ffbpa_pkg::MAX_ENTRIES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  ffbpa_pkg::cmd_word_t    request,
  input  logic                    done,
  input  ffbpa_pkg::result_word_t result,
  output int                      mismatches,
  output int                      outstanding,
  output int                      words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [11:0] slot_offset [MAX_ENTRIES];
  logic [12:0] slot_size   [MAX_ENTRIES];
  logic        slot_free   [MAX_ENTRIES];
  int          used_tally;
  int          bump_ptr;
  int          slot_total;

  ffbpa_pkg::result_word_t pool_outcomes [$];

  initial begin
    mismatches    = 0;
    outstanding   = 0;
    words_checked = 0;
  end

  function automatic void wipe_pool();
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      slot_offset[i] = '0;
      slot_size[i]   = '0;
      slot_free[i]   = 1'b0;
    end
    used_tally = 0;
    bump_ptr   = 0;
    slot_total = 0;
  endfunction

  function automatic ffbpa_pkg::result_word_t pool_step(ffbpa_pkg::cmd_word_t w);
    ffbpa_pkg::result_word_t r;
    logic [2:0]   st;
    int           got_offset;
    int           hit;
    int           sz;
    got_offset = 0;
    hit        = -1;
    sz         = w.request_size;
    if (w.command[1]) begin
      wipe_pool();
      st = ffbpa_pkg::ST_NULL_CLEAR;
    end else if (w.command == ffbpa_pkg::CMD_ALLOC) begin
      if (sz == 0 || sz > POOL_BYTES) begin
        st = ffbpa_pkg::ST_BAD_SIZE;
      end else if (used_tally + sz > POOL_BYTES) begin
        st = ffbpa_pkg::ST_NO_MEM;
      end else if (slot_total >= MAX_ENTRIES) begin
        st = ffbpa_pkg::ST_FULL;
      end else begin
        for (int i = 0; i < slot_total; i++) begin
          if (hit < 0 && slot_free[i] && slot_size[i] >= sz) hit = i;
        end
        if (hit >= 0) begin
          slot_free[hit] = 1'b0;
          used_tally     = used_tally + slot_size[hit];
          got_offset     = slot_offset[hit];
          st             = ffbpa_pkg::ST_REUSED;
        end else if (bump_ptr + sz > POOL_BYTES) begin
          st = ffbpa_pkg::ST_NO_MEM;
        end else begin
          slot_offset[slot_total] = bump_ptr[11:0];
          slot_size[slot_total]   = sz[12:0];
          slot_free[slot_total]   = 1'b0;
          got_offset              = bump_ptr;
          slot_total              = slot_total + 1;
          bump_ptr                = bump_ptr + sz;
          used_tally              = used_tally + sz;
          st                      = ffbpa_pkg::ST_NEW;
        end
      end
    end else if (w.offset_is_null) begin
      st = ffbpa_pkg::ST_NULL_CLEAR;
    end else begin
      for (int i = 0; i < slot_total; i++) begin
        if (hit < 0 && !slot_free[i] && slot_offset[i] == w.block_offset) hit = i;
      end
      if (hit >= 0) begin
        slot_free[hit] = 1'b1;
        used_tally = (used_tally >= slot_size[hit]) ? used_tally - slot_size[hit] : 0;
        st = ffbpa_pkg::ST_FREED;
      end else begin
        st = ffbpa_pkg::ST_BAD_FREE;
      end
    end
    r.status        = st;
    r.result_offset = got_offset[11:0];
    r.used_bytes    = used_tally[12:0];
    r.block_count   = slot_total[4:0];
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [15:0] want, logic [15:0] got);
    if (mismatches < 10) begin
      $display("%0t: %s differs: expected %h, got %h", $realtime, what, want, got);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    ffbpa_pkg::result_word_t want;
    if (rst) begin
      wipe_pool();
      pool_outcomes.delete();
    end else begin
      if (done) begin
        if (pool_outcomes.size() == 0) begin
          note_mismatch("result word with nothing pending", 16'h0, 16'(result));
        end else begin
          want = pool_outcomes.pop_front();
          if (result.status !== want.status)
            note_mismatch("status", 16'(want.status), 16'(result.status));
          if (result.result_offset !== want.result_offset)
            note_mismatch("result_offset", 16'(want.result_offset), 16'(result.result_offset));
          if (result.used_bytes !== want.used_bytes)
            note_mismatch("used_bytes", 16'(want.used_bytes), 16'(result.used_bytes));
          if (result.block_count !== want.block_count)
            note_mismatch("block_count", 16'(want.block_count), 16'(result.block_count));
          words_checked++;
        end
      end
      if (start && !busy) pool_outcomes.push_back(pool_step(request));
    end
    outstanding = pool_outcomes.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench top for the pool allocator: clock, reset, command stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_CLEAR     = 2'd2;
  localparam logic [1:0] CMD_CLEAR_ALT = 2'd3;
  localparam int         RANDOM_WORDS  = 1300;
  localparam int         CYCLE_LIMIT   = 400000;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  ffbpa_pkg::cmd_word_t    request = '0;
  logic                    busy;
  logic                    done;
  ffbpa_pkg::result_word_t result;

  int mismatches;
  int outstanding;
  int words_checked;
  int words_sent;
  int cycles;

  logic [11:0] live_offsets [$];

  always #2 clk = ~clk;

  first_fit_block_pool_allocator_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  ffbpa_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .request       (request),
    .done          (done),
    .result        (result),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .words_checked (words_checked)
  );

  initial cycles = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offsets handed out by the block feed later frees so that most of them hit live blocks.
  always @(posedge clk) begin
    if (!rst && done && (result.status == ffbpa_pkg::ST_NEW ||
                         result.status == ffbpa_pkg::ST_REUSED)) begin
      live_offsets.push_back(result.result_offset);
      if (live_offsets.size() > 32) void'(live_offsets.pop_front());
    end
  end

  function automatic ffbpa_pkg::cmd_word_t make_word(logic [1:0] cmd, int size, int offset,
                                                     bit is_null);
    ffbpa_pkg::cmd_word_t w;
    w.command        = cmd;
    w.request_size   = size[15:0];
    w.block_offset   = offset[11:0];
    w.offset_is_null = is_null;
    return w;
  endfunction

  function automatic int random_size();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 300);
    if (pick < 85) return $urandom_range(301, 4096);
    if (pick < 92) return $urandom_range(4097, 65535);
    if (pick < 95) return 0;
    return $urandom_range(3800, 4096);
  endfunction

  function automatic ffbpa_pkg::cmd_word_t random_word();
    ffbpa_pkg::cmd_word_t w;
    int                   pick;
    int                   idx;
    int                   offset;
    w    = ffbpa_pkg::cmd_word_t'(31'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      w.command      = ffbpa_pkg::CMD_ALLOC;
      w.request_size = 16'(random_size());
    end else if (pick < 85) begin
      w.command        = ffbpa_pkg::CMD_FREE;
      w.offset_is_null = ($urandom_range(0, 9) == 0);
      offset           = $urandom_range(0, 4095);
      if (live_offsets.size() > 0 && $urandom_range(0, 3) != 0) begin
        idx    = $urandom_range(0, live_offsets.size() - 1);
        offset = live_offsets[idx];
        live_offsets.delete(idx);
      end
      w.block_offset = offset[11:0];
    end else if (pick < 90) begin
      w.command = ($urandom_range(0, 1) == 0) ? CMD_CLEAR : CMD_CLEAR_ALT;
    end
    return w;
  endfunction

  task automatic issue(ffbpa_pkg::cmd_word_t w, int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start   <= 1'b1;
    request <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
  endtask

  initial begin
    int idle_pct;
    int phase;
    words_sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    issue(make_word(CMD_CLEAR, 0, 0, 0), 0);
    issue(make_word(ffbpa_pkg::CMD_ALLOC, 0, 0, 0), 0);
    issue(make_word(ffbpa_pkg::CMD_ALLOC, 65535, 4095, 1), 0);
    issue(make_word(ffbpa_pkg::CMD_ALLOC, 4097, 0, 0), 0);
    issue(make_word(ffbpa_pkg::CMD_ALLOC, 4096, 0, 0), 0);
    issue(make_word(ffbpa_pkg::CMD_ALLOC, 1, 0, 0), 0);
    issue(make_word(ffbpa_pkg::CMD_FREE, 0, 0, 1), 0);
    issue(make_word(ffbpa_pkg::CMD_FREE, 0, 4095, 0), 0);
    issue(make_word(ffbpa_pkg::CMD_FREE, 0, 0, 0), 0);
    issue(make_word(ffbpa_pkg::CMD_FREE, 0, 0, 0), 0);
    issue(make_word(ffbpa_pkg::CMD_ALLOC, 10, 0, 0), 0);
    issue(make_word(CMD_CLEAR_ALT, 65535, 4095, 1), 0);
    issue(make_word(ffbpa_pkg::CMD_ALLOC, 3000, 0, 0), 0);
    issue(make_word(ffbpa_pkg::CMD_ALLOC, 1000, 0, 0), 0);
    issue(make_word(ffbpa_pkg::CMD_FREE, 0, 0, 0), 0);
    issue(make_word(ffbpa_pkg::CMD_FREE, 0, 3000, 0), 0);
    issue(make_word(ffbpa_pkg::CMD_ALLOC, 3500, 0, 0), 0);
    issue(make_word(CMD_CLEAR, 0, 0, 0), 0);

    while (words_sent < RANDOM_WORDS + 18) begin
      phase    = (words_sent - 18) * 3 / RANDOM_WORDS;
      idle_pct = (phase == 0) ? 0 : (phase == 1) ? 66 : 8;
      if ($urandom_range(0, 99) < 8) begin
        // Clear, then fill the table with small blocks until it reports full.
        issue(make_word(CMD_CLEAR, $urandom, $urandom, 0), idle_pct);
        repeat (17) begin
          issue(make_word(ffbpa_pkg::CMD_ALLOC, $urandom_range(1, 200), $urandom, 0),
                idle_pct);
        end
      end else begin
        issue(random_word(), idle_pct);
      end
    end
    start <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Covered %0d command words across three sender pacing phases;", words_sent);
    $display("%0d result words compared field by field.", words_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
